/* rtl/hashed_key_dedup_cache_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dedup cache core
// Shared wrappers around concurrent assertions clocked on clk, reset by rst.
// ----------------------------------------------------------------------------
`ifndef HASHED_KEY_DEDUP_CACHE_CORE_ASSERT_SVH
`define HASHED_KEY_DEDUP_CACHE_CORE_ASSERT_SVH

// same-cycle implication
`define HKDC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HKDC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hkdc_pkg.sv */
// ----------------------------------------------------------------------------
// hkdc_pkg
// Shared constants and types of the hashed key dedup cache.
// ----------------------------------------------------------------------------
package hkdc_pkg;

  // default sizes
  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int MAX_KEY_BYTES_DEF = 48;
  localparam int FIFO_DEPTH        = 2;

  // payload widths
  localparam int WORD_W   = 64;
  localparam int COUNT_W  = 4;
  localparam int STATUS_W = 2;
  localparam int HASH_W   = 64;

  // hash constants
  localparam logic [63:0] HASH_MUL_LEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HASH_MUL_MIX = 64'hC2B2AE3D27D4EB4F;
  localparam int          HASH_SHIFT   = 29;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT  = 2'd1;
  localparam logic                  CACHE_ENABLE_RST = 1'b1;
  localparam logic [5:0]            SHORT_LIMIT_RST  = 6'd24;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_HIT    = 2'd0,
    STATUS_MISS   = 2'd1,
    STATUS_BYPASS = 2'd2
  } status_t;

endpackage

/* rtl/hashed_key_dedup_cache_core.sv */
// ----------------------------------------------------------------------------
// hashed_key_dedup_cache_core
// Direct-mapped dedup cache for short strings: front packs and classifies,
// back hashes, looks up and refills the table.
//
//   channel  | direction | transfer when      | payload
//   ---------+-----------+--------------------+-------------------------------
//   input    | in        | push && !full      | key_word byte_count is_last is_key
//   result   | out       | pop && !empty      | status slot_index key_hash
//   config   | in        | cfg_we             | cfg_index cfg_data
//
// Key words are taken one per cycle while full is low; a result appears only
// for a last word. The back end passes a bypass string straight to the result;
// a cacheable one is hashed, its stored words are compared one by one and, on
// a miss, refilled in the byte memory (KEY_WORDS = MAX_KEY_BYTES/8 rounded up,
// 6 by default). After reset the table is swept with full held high.
// A two-deep job queue and a two-deep result queue let either side stall.
// ----------------------------------------------------------------------------
module hashed_key_dedup_cache_core
  import hkdc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
  localparam int IDX_W        = $clog2(TABLE_ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst,
  // input queue side
  input  logic                  push,
  output logic                  full,
  input  logic [WORD_W-1:0]     key_word,
  input  logic [COUNT_W-1:0]    byte_count,
  input  logic                  is_last,
  input  logic                  is_key,
  // result queue side
  output logic                  empty,
  input  logic                  pop,
  output logic [STATUS_W-1:0]   status,
  output logic [IDX_W-1:0]      slot_index,
  output logic [HASH_W-1:0]     key_hash,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int KEY_WORDS = (MAX_KEY_BYTES + 7) / 8;
  localparam int LEN_W     = $clog2(MAX_KEY_BYTES + 1);
  localparam int JOB_W     = KEY_WORDS * WORD_W + LEN_W + 1;
  localparam int RES_W     = STATUS_W + IDX_W + HASH_W;

  logic             take;
  logic             clearing;
  logic             job_push;
  logic [JOB_W-1:0] job_wdata;
  logic [JOB_W-1:0] job_rdata;
  logic             job_pop;
  logic             job_full;
  logic             job_empty;
  logic             res_push;
  logic [RES_W-1:0] res_wdata;
  logic [RES_W-1:0] res_rdata;
  logic             res_full;

  // input transfer gating
  assign full = clearing || job_full;
  assign take = push && !full;

  hkdc_front #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .key_word   (key_word),
    .byte_count (byte_count),
    .is_last    (is_last),
    .is_key     (is_key),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .job_push   (job_push),
    .job_data   (job_wdata)
  );

  hkdc_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (FIFO_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_wdata),
    .pop   (job_pop),
    .rdata (job_rdata),
    .full  (job_full),
    .empty (job_empty)
  );

  hkdc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_data  (job_rdata),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wdata),
    .clearing  (clearing)
  );

  hkdc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (FIFO_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .pop   (pop),
    .rdata (res_rdata),
    .full  (res_full),
    .empty (empty)
  );

  // result fields
  assign status     = res_rdata[RES_W-1 -: STATUS_W];
  assign slot_index = res_rdata[HASH_W +: IDX_W];
  assign key_hash   = res_rdata[HASH_W-1:0];

endmodule

/* rtl/hkdc_ram.sv */
// ----------------------------------------------------------------------------
// hkdc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hkdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/hkdc_fifo.sv */
// ----------------------------------------------------------------------------
// hkdc_fifo
// Small register FIFO; used for the job queue and the result queue.
// ----------------------------------------------------------------------------
module hkdc_fifo
  import hkdc_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

/* rtl/hkdc_front.sv */
// ----------------------------------------------------------------------------
// hkdc_front
// Packs key words into the string buffer, holds the configuration registers
// and classifies each finished string as cacheable or bypass.
// ----------------------------------------------------------------------------
module hkdc_front
  import hkdc_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
  localparam int KEY_WORDS    = (MAX_KEY_BYTES + 7) / 8,
  localparam int LEN_W        = $clog2(MAX_KEY_BYTES + 1),
  localparam int JOB_W        = KEY_WORDS * WORD_W + LEN_W + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  // accepted input transfer
  input  logic                  take,
  input  logic [WORD_W-1:0]     key_word,
  input  logic [COUNT_W-1:0]    byte_count,
  input  logic                  is_last,
  input  logic                  is_key,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // job to the back end
  output logic                  job_push,
  output logic [JOB_W-1:0]      job_data
);

  localparam int SUM_W    = LEN_W + 1;
  localparam int CMP_W    = (LEN_W > 6) ? LEN_W : 6;
  localparam int KEY_BITS = KEY_WORDS * WORD_W;

  logic             cache_enable;
  logic [5:0]       short_value_limit;
  logic [7:0]       key_buffer [MAX_KEY_BYTES];
  logic [7:0]       buf_next   [MAX_KEY_BYTES];
  logic [LEN_W-1:0] key_length;
  logic             key_too_long;
  logic             in_string;
  logic             cur_is_key;

  logic [LEN_W-1:0]   len_eff;
  logic               long_eff;
  logic               key_eff;
  logic [COUNT_W-1:0] cnt;
  logic [SUM_W-1:0]   sum;
  logic               fits;
  logic               too_long_next;
  logic [LEN_W-1:0]   len_next;
  logic [SUM_W-1:0]   off;
  logic               bypass;
  logic [KEY_BITS-1:0] key_bits;

  // byte packing after the bytes already collected
  always_comb begin
    len_eff       = in_string ? key_length : '0;
    long_eff      = in_string && key_too_long;
    key_eff       = in_string ? cur_is_key : is_key;
    cnt           = (byte_count > COUNT_W'(8)) ? COUNT_W'(8) : byte_count;
    sum           = SUM_W'(len_eff) + SUM_W'(cnt);
    too_long_next = long_eff || (sum > SUM_W'(MAX_KEY_BYTES));
    fits          = !too_long_next;
    len_next      = fits ? LEN_W'(sum) : len_eff;
    off           = '0;
    for (int p = 0; p < MAX_KEY_BYTES; p++) begin
      buf_next[p] = key_buffer[p];
      off = SUM_W'(p) - SUM_W'(len_eff);
      if (fits && (SUM_W'(p) >= SUM_W'(len_eff)) && (off < SUM_W'(cnt))) begin
        buf_next[p] = key_word[{off[2:0], 3'b000} +: 8];
      end
    end
  end

  // eligibility of the finished string
  assign bypass = !cache_enable || too_long_next ||
                  (!key_eff && (CMP_W'(len_next) > CMP_W'(short_value_limit)));

  // job word image, zero padded past the byte limit
  always_comb begin
    key_bits = '0;
    for (int q = 0; q < KEY_WORDS * 8; q++) begin
      if (q < MAX_KEY_BYTES) begin
        key_bits[q*8 +: 8] = buf_next[q];
      end
    end
  end

  assign job_push = take && is_last;
  assign job_data = {bypass, len_next, key_bits};

  // string state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length        <= '0;
      key_too_long      <= 1'b0;
      in_string         <= 1'b0;
      cur_is_key        <= 1'b0;
      cache_enable      <= CACHE_ENABLE_RST;
      short_value_limit <= SHORT_LIMIT_RST;
    end else begin
      if (take) begin
        key_length   <= len_next;
        key_too_long <= too_long_next;
        in_string    <= !is_last;
        cur_is_key   <= key_eff;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CACHE_ENABLE: cache_enable      <= cfg_data[0];
          REG_SHORT_LIMIT:  short_value_limit <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  // buffer payload
  always_ff @(posedge clk) begin
    if (take) begin
      key_buffer <= buf_next;
    end
  end

endmodule

/* rtl/hkdc_back.sv */
// ----------------------------------------------------------------------------
// hkdc_back
// Hashes each cacheable string, looks up its slot, compares stored bytes one
// word a cycle and refills the slot on a miss. Also clears the table after
// reset.
// ----------------------------------------------------------------------------
`include "hashed_key_dedup_cache_core_assert.svh"

module hkdc_back
  import hkdc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
  localparam int KEY_WORDS    = (MAX_KEY_BYTES + 7) / 8,
  localparam int LEN_W        = $clog2(MAX_KEY_BYTES + 1),
  localparam int IDX_W        = $clog2(TABLE_ENTRIES),
  localparam int JOB_W        = KEY_WORDS * WORD_W + LEN_W + 1,
  localparam int RES_W        = STATUS_W + IDX_W + HASH_W
) (
  input  logic             clk,
  input  logic             rst,
  // job queue side
  input  logic [JOB_W-1:0] job_data,
  input  logic             job_empty,
  output logic             job_pop,
  // result queue side
  input  logic             res_full,
  output logic             res_push,
  output logic [RES_W-1:0] res_data,
  // table sweep in progress
  output logic             clearing
);

  localparam int WORD_BITS = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int KEY_BITS  = KEY_WORDS * WORD_W;
  localparam int META_W    = 1 + HASH_W + LEN_W;
  localparam int BYTES_A_W = IDX_W + WORD_BITS;
  localparam int POS_W     = WORD_BITS + 3;
  localparam int PL_W      = POS_W + LEN_W;
  localparam logic [WORD_BITS-1:0] LAST_WORD = WORD_BITS'(KEY_WORDS - 1);
  localparam logic [IDX_W-1:0]     LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MIX, S_MUL_LO, S_MUL_HI, S_MUL_X,
    S_FOLD, S_LOOK, S_CMP, S_WRITE, S_DONE
  } state_t;

  state_t state;

  // job and working registers
  logic [WORD_W-1:0]    job_words [KEY_WORDS];
  logic [LEN_W-1:0]     job_len;
  logic [HASH_W-1:0]    mix_x;
  logic [63:0]          p_lo;
  logic [31:0]          p_hi;
  logic [31:0]          p_x;
  logic [HASH_W-1:0]    hash;
  logic [WORD_BITS-1:0] w;
  logic                 eq_acc;
  logic [IDX_W-1:0]     clr_cnt;
  status_t              res_status;
  logic [IDX_W-1:0]     res_slot;
  logic [HASH_W-1:0]    res_hash;

  // datapath nets
  logic [63:0]          prefix;
  logic [63:0]          mix_val;
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [63:0]          mul_p;
  logic [63:0]          fold_sum;
  logic [WORD_W-1:0]    cur_word;
  logic                 word_eq;
  logic [POS_W-1:0]     pos;
  logic                 meta_match;
  logic [IDX_W-1:0]     slot;

  // memory ports
  logic                 meta_we;
  logic [IDX_W-1:0]     meta_waddr;
  logic [META_W-1:0]    meta_wdata;
  logic [META_W-1:0]    meta_rdata;
  logic                 bytes_we;
  logic [BYTES_A_W-1:0] bytes_waddr;
  logic [BYTES_A_W-1:0] bytes_raddr;
  logic [WORD_W-1:0]    bytes_rdata;
  logic [WORD_BITS-1:0] rd_w;

  assign slot     = hash[IDX_W-1:0];
  assign clearing = (state == S_CLEAR);
  assign job_pop  = (state == S_IDLE) && !job_empty;
  assign res_push = (state == S_DONE) && !res_full;
  assign res_data = {res_status, res_slot, res_hash};

  // first eight bytes, zero filled past the length, mixed with the length
  always_comb begin
    prefix = '0;
    for (int b = 0; b < 8; b++) begin
      if (LEN_W'(b) < job_len) begin
        prefix[b*8 +: 8] = job_words[0][b*8 +: 8];
      end
    end
    mix_val = prefix ^ (64'(job_len) * HASH_MUL_LEN);
  end

  // shared 32x32 multiplier for the 64-bit mix product
  always_comb begin
    case (state)
      S_MUL_HI: begin
        mul_a = mix_x[63:32];
        mul_b = HASH_MUL_MIX[31:0];
      end
      S_MUL_X: begin
        mul_a = mix_x[31:0];
        mul_b = HASH_MUL_MIX[63:32];
      end
      default: begin
        mul_a = mix_x[31:0];
        mul_b = HASH_MUL_MIX[31:0];
      end
    endcase
    mul_p    = {32'b0, mul_a} * {32'b0, mul_b};
    fold_sum = p_lo + {p_hi + p_x, 32'b0};
  end

  // masked compare of one stored word
  always_comb begin
    cur_word = job_words[w];
    word_eq  = 1'b1;
    pos      = '0;
    for (int b = 0; b < 8; b++) begin
      pos = {w, 3'(b)};
      if ((PL_W'(pos) < PL_W'(job_len)) &&
          (bytes_rdata[b*8 +: 8] != cur_word[b*8 +: 8])) begin
        word_eq = 1'b0;
      end
    end
    meta_match = meta_rdata[META_W-1] &&
                 (meta_rdata[LEN_W +: HASH_W] == hash) &&
                 (meta_rdata[LEN_W-1:0] == job_len);
  end

  // memory addressing
  always_comb begin
    rd_w        = (state == S_CMP) ? w + 1'b1 : '0;
    bytes_raddr = {slot, rd_w};
    bytes_we    = (state == S_WRITE);
    bytes_waddr = {slot, w};
    meta_we     = (state == S_CLEAR) || ((state == S_WRITE) && (w == '0));
    meta_waddr  = (state == S_CLEAR) ? clr_cnt : slot;
    meta_wdata  = (state == S_CLEAR) ? '0 : {1'b1, hash, job_len};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!job_empty) begin
            for (int k = 0; k < KEY_WORDS; k++) begin
              job_words[k] <= job_data[k*WORD_W +: WORD_W];
            end
            job_len <= job_data[KEY_BITS +: LEN_W];
            if (job_data[JOB_W-1]) begin
              res_status <= STATUS_BYPASS;
              res_slot   <= '0;
              res_hash   <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_MIX;
            end
          end
        end
        S_MIX: begin
          mix_x <= mix_val;
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          p_lo  <= mul_p;
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          p_hi  <= mul_p[31:0];
          state <= S_MUL_X;
        end
        S_MUL_X: begin
          p_x   <= mul_p[31:0];
          state <= S_FOLD;
        end
        S_FOLD: begin
          hash  <= fold_sum ^ (fold_sum >> HASH_SHIFT);
          state <= S_LOOK;
        end
        S_LOOK: begin
          w      <= '0;
          eq_acc <= 1'b1;
          state  <= S_CMP;
        end
        S_CMP: begin
          eq_acc <= eq_acc && word_eq;
          if (w == LAST_WORD) begin
            res_slot <= slot;
            res_hash <= hash;
            w        <= '0;
            if (eq_acc && word_eq && meta_match) begin
              res_status <= STATUS_HIT;
              state      <= S_DONE;
            end else begin
              res_status <= STATUS_MISS;
              state      <= S_WRITE;
            end
          end else begin
            w <= w + 1'b1;
          end
        end
        S_WRITE: begin
          if (w == LAST_WORD) begin
            state <= S_DONE;
          end else begin
            w <= w + 1'b1;
          end
        end
        S_DONE: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  hkdc_ram #(
    .WIDTH (META_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (slot),
    .rdata (meta_rdata)
  );

  hkdc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES << WORD_BITS)
  ) u_bytes_ram (
    .clk   (clk),
    .we    (bytes_we),
    .waddr (bytes_waddr),
    .wdata (cur_word),
    .raddr (bytes_raddr),
    .rdata (bytes_rdata)
  );

  // checks
  `HKDC_ASSERT_NOW(a_push_room, res_push, !res_full, "result pushed into a full queue")
  `HKDC_ASSERT_NOW(a_pop_data, job_pop, !job_empty && !clearing, "job popped while unavailable")
  `HKDC_ASSERT_NOW(a_clear_wr, clearing, meta_we && !meta_wdata[META_W-1], "sweep must write invalid")
  `HKDC_ASSERT_NXT(a_clear_run, clearing && (clr_cnt != LAST_SLOT), clearing, "sweep ended early")
  `HKDC_ASSERT_NOW(a_bypass_zero, res_push && (res_status == STATUS_BYPASS), (res_hash == '0) && (res_slot == '0), "bypass result not zeroed")

endmodule
